@@ src/pls_pkg.sv @@
// shared types, opcodes and sizes for the positional list store
package pls_pkg;

    // list capacity and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 4;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W = 32;

    // opcodes, code 7 is unused and acts as a no-op
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_DEL_AT     = 3'd5,
        OP_READ_ALL   = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_POS   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // input transfer payload
    typedef struct packed {
        logic [2:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] read_value;
        logic                    has_value;
        logic                    last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic read_nonempty;
        logic rd_last;
    } t_dp_stat;

endpackage

@@ src/pls_ctrl.sv @@
// controller state machine for the positional list store
module pls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  pls_pkg::t_dp_stat i_stat,
    output pls_pkg::t_dp_cmd  o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);
    import pls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.read_nonempty) begin
                    n_state = S_READ;
                end else if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.rd_load = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid holds while stalled, sets on each new result
    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.exec || o_cmd.rd_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/pls_dp.sv @@
// datapath: entry registers, count, readout index and result register
module pls_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pls_pkg::t_in_item i_item,
    input  pls_pkg::t_dp_cmd  i_cmd,
    output pls_pkg::t_dp_stat o_stat,
    output pls_pkg::t_out_item o_item
);
    import pls_pkg::*;

    t_in_item                r_item;
    logic signed [VAL_W-1:0] r_entries [DEPTH];
    logic signed [VAL_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_idx;
    t_out_item               r_out;

    logic             is_empty, is_full, pos_bad;
    logic [CMP_W-1:0] pos_ext, cnt_ext, pos_inc;
    logic [CNT_W-1:0] at_idx;
    logic             do_ins, do_del;
    t_status          status;

    // checks on the captured item
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign pos_ext  = CMP_W'(r_item.position);
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_bad  = (pos_ext >= cnt_ext);
    assign pos_inc  = pos_ext + CMP_W'(1);

    // decode operation, status and target index
    always_comb begin
        status = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        at_idx = '0;
        n_count = r_count;
        case (t_op'(r_item.opcode))
            OP_PUSH_FRONT: begin
                if (is_full) status = ST_FULL;
                else do_ins = 1'b1;
            end
            OP_PUSH_BACK: begin
                at_idx = r_count;
                if (is_full) status = ST_FULL;
                else do_ins = 1'b1;
            end
            OP_INS_AFTER: begin
                at_idx = CNT_W'(pos_inc);
                if (is_empty) status = ST_EMPTY;
                else if (pos_bad) status = ST_POS;
                else if (is_full) status = ST_FULL;
                else do_ins = 1'b1;
            end
            OP_POP_FRONT: begin
                if (is_empty) status = ST_EMPTY;
                else do_del = 1'b1;
            end
            OP_POP_BACK: begin
                if (is_empty) status = ST_EMPTY;
                else n_count = r_count - CNT_W'(1);
            end
            OP_DEL_AT: begin
                at_idx = CNT_W'(pos_ext);
                if (is_empty) status = ST_EMPTY;
                else if (pos_bad) status = ST_POS;
                else do_del = 1'b1;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (do_ins) n_count = r_count + CNT_W'(1);
        if (do_del) n_count = r_count - CNT_W'(1);
    end

    // per-entry shift for insert and delete
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_ins) begin
                if (CNT_W'(i) == at_idx) begin
                    n_entries[i] = r_item.value;
                end else if (i > 0 && CNT_W'(i) > at_idx) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if (i < DEPTH - 1 && CNT_W'(i) >= at_idx) begin
                    n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // status back to the controller
    assign o_stat.read_nonempty = (t_op'(r_item.opcode) == OP_READ_ALL) && !is_empty;
    assign o_stat.rd_last       = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // count is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_idx  <= '0;
        end
        if (i_cmd.exec) begin
            r_entries        <= n_entries;
            r_out.status     <= status;
            r_out.read_value <= '0;
            r_out.has_value  <= 1'b0;
            r_out.last       <= 1'b1;
        end
        if (i_cmd.rd_load) begin
            r_out.status     <= ST_OK;
            r_out.read_value <= r_entries[r_idx];
            r_out.has_value  <= 1'b1;
            r_out.last       <= o_stat.rd_last;
            r_idx            <= r_idx + IDX_W'(1);
        end
    end

    assign o_item = r_out;

endmodule

@@ src/positional_list_store_core.sv @@
// top level of the positional list store
// Ordered list of up to DEPTH signed 32-bit entries held front to back in
// registers. Every operation except readout gives a single result: the item
// is captured at the input transfer, then the list shifts by one place in
// parallel where the operation needs it and the result is loaded into the
// output register once that register is free. Readout of n entries passes
// through the decode state and then gives n result transfers, one per cycle
// while the output is not stalled, read through a single index counter; an
// empty list gives one result like any other operation. Output stall on a
// full output register holds back the next result. Input is stalled until
// the last result of the current item is in the output register, and the
// output register holds a result under output stall while the next item is
// taken. Failed operations report a status and leave the list as it was.
module positional_list_store_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pls_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pls_pkg::t_out_item  o_out_item
);
    import pls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // list storage and result
    pls_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

endmodule
